// ===== rtl/core/serial_command_frame_receiver_assert.svh =====
// Assertion macros for the serial command frame receiver checkers.
// Included by the checker file; depends on nothing else.
`ifndef SERIAL_COMMAND_FRAME_RECEIVER_ASSERT_SVH
`define SERIAL_COMMAND_FRAME_RECEIVER_ASSERT_SVH

// Same-cycle implication, disabled while reset is active.
`define SCFR_ASSERT_IMP(LBL, CK, RSTN, ANT, CON) \
    LBL: assert property (@(posedge CK) disable iff (!RSTN) (ANT) |-> (CON)) \
        else $error("scfr check failed");

// Next-cycle implication, disabled while reset is active.
`define SCFR_ASSERT_NXT(LBL, CK, RSTN, ANT, CON) \
    LBL: assert property (@(posedge CK) disable iff (!RSTN) (ANT) |=> (CON)) \
        else $error("scfr check failed");

`endif

// ===== rtl/core/scfr_pkg.sv =====
// Shared types and constants of the serial command frame receiver.
// No dependencies; compiled first.
package scfr_pkg;

    localparam int BYTE_W        = 8;
    localparam int DEFAULT_DEPTH = 128;

    typedef logic [BYTE_W-1:0] byte_t;

    localparam byte_t HDR_FIRST  = 8'hA5;
    localparam byte_t HDR_SECOND = 8'h5A;
    localparam byte_t NO_COMMAND = 8'hFF;

    // Write request into the frame stores (address travels separately).
    typedef struct packed {
        logic  en;
        byte_t data;
        byte_t psum;
    } mem_wr_t;

    // Registered read data, already forwarded.
    typedef struct packed {
        byte_t prev_byte;   // byte store at index-1
        byte_t prev_psum;   // prefix sum at index-1
        byte_t prev2_psum;  // prefix sum at index-2
    } mem_rd_t;

    typedef struct packed {
        logic  frame_done;
        logic  sum_ok;
        byte_t command_code;
    } result_t;

endpackage

// ===== rtl/core/scfr_if.sv =====
// Valid/ready channel interfaces for received bytes and frame results.
// Depends on scfr_pkg.
interface scfr_rx_if;
    logic                valid;
    logic                ready;
    scfr_pkg::byte_t     rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface scfr_res_if;
    logic                valid;
    logic                ready;
    logic                frame_done;
    logic                sum_ok;
    scfr_pkg::byte_t     command_code;

    modport source (output valid, output frame_done, output sum_ok, output command_code,
                    input ready);
    modport sink   (input valid, input frame_done, input sum_ok, input command_code,
                    output ready);
endinterface

// ===== rtl/core/scfr_frame_mem.sv =====
// Byte store and prefix-sum store: one write port, registered reads, forwarding.
// Depends on scfr_pkg.
module scfr_frame_mem #(
    parameter int DEPTH = scfr_pkg::DEFAULT_DEPTH,
    parameter int IDX_W = $clog2(DEPTH)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  scfr_pkg::mem_wr_t   wr,
    input  logic [IDX_W-1:0]    wr_addr,
    input  logic [IDX_W-1:0]    rd_addr_a,
    input  logic [IDX_W-1:0]    rd_addr_b,
    output scfr_pkg::mem_rd_t   rd
);
    import scfr_pkg::*;

    byte_t byte_mem [DEPTH];
    byte_t psum_mem [DEPTH];

    byte_t byte_a_reg;
    byte_t psum_a_reg;
    byte_t psum_b_reg;
    byte_t wr_byte_reg;
    byte_t wr_psum_reg;
    logic  fwd_a_reg;
    logic  fwd_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            byte_mem[wr_addr] <= wr.data;
            psum_mem[wr_addr] <= wr.psum;
        end
        byte_a_reg  <= byte_mem[rd_addr_a];
        psum_a_reg  <= psum_mem[rd_addr_a];
        psum_b_reg  <= psum_mem[rd_addr_b];
        wr_byte_reg <= wr.data;
        wr_psum_reg <= wr.psum;
    end

    // Read-during-write returns old data: flag the hit and bypass next cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_a_reg <= 1'b0;
            fwd_b_reg <= 1'b0;
        end
        else
        begin
            fwd_a_reg <= wr.en && (wr_addr == rd_addr_a);
            fwd_b_reg <= wr.en && (wr_addr == rd_addr_b);
        end
    end

    always_comb
    begin
        rd.prev_byte  = fwd_a_reg ? wr_byte_reg : byte_a_reg;
        rd.prev_psum  = fwd_a_reg ? wr_psum_reg : psum_a_reg;
        rd.prev2_psum = fwd_b_reg ? wr_psum_reg : psum_b_reg;
    end

endmodule

// ===== rtl/core/scfr_out_buf.sv =====
// Two-entry output buffer (output register plus skid register) for results.
// Depends on scfr_pkg and scfr_res_if.
module scfr_out_buf (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  scfr_pkg::result_t   push_res,
    output logic                push_ready,
    scfr_res_if.source          res
);
    import scfr_pkg::*;

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_data_reg;
    result_t skid_data_reg;
    logic    take;

    always_comb
    begin
        take             = !out_valid_reg || res.ready;
        push_ready       = !skid_valid_reg;
        res.valid        = out_valid_reg;
        res.frame_done   = out_data_reg.frame_done;
        res.sum_ok       = out_data_reg.sum_ok;
        res.command_code = out_data_reg.command_code;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= push;
            end
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : push_res;
        end
        else if (push)
        begin
            skid_data_reg <= push_res;
        end
    end

endmodule

// ===== rtl/core/serial_command_frame_receiver.sv =====
// Serial command frame receiver, top level.
// Depends on scfr_pkg, scfr_if, scfr_frame_mem and scfr_out_buf.
//
// Takes one received byte per word on rx and returns one result word on res for
// every byte: frame_done, sum_ok and command_code. A byte is taken every clock
// cycle while the result side keeps up; a two-entry output buffer lets one more
// byte in while a result waits, after which rx.ready drops until res drains.
// The result of a byte is registered in the output buffer before it is offered.
// The sequence 0xA5 0x5A restarts the frame at entry 0; entry 0 is the frame
// length, and the byte that brings the stored count to that length ends the
// frame. The frame bytes and their running modulo-256 sums live in two
// synchronous memories of BUFFER_DEPTH entries that are read at the two entries
// below the next write index, with a bypass for the entry written in the same
// cycle; the check compares the sum of entries 0..len-3 with entry len-2 and
// returns entry 1 as the command, or 255 on a failed check or a length below 3.
// Past BUFFER_DEPTH-1 the write index holds and later bytes overwrite the last
// entry. No clearing pass follows reset.
module serial_command_frame_receiver #(
    parameter int BUFFER_DEPTH = scfr_pkg::DEFAULT_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    scfr_rx_if.sink     rx,
    scfr_res_if.source  res
);
    import scfr_pkg::*;

    localparam int IDX_W = $clog2(BUFFER_DEPTH);
    localparam int CNT_W = IDX_W + 1;
    localparam int CMP_W = (CNT_W > BYTE_W) ? CNT_W : BYTE_W;
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(BUFFER_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(BUFFER_DEPTH - 1);
    localparam logic [IDX_W-1:0] IDX_ZERO  = '0;
    localparam logic [IDX_W-1:0] IDX_CMD   = IDX_W'(1);
    localparam logic [IDX_W-1:0] IDX_CHECK = IDX_W'(2);

    // Frame state
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic             hdr_reg;
    logic             hdr_next;
    byte_t            len_reg;     // copy of entry 0
    byte_t            cmd_reg;     // copy of entry 1

    logic             accept;
    logic             in_ready;
    byte_t            b;
    logic             is_first;
    logic             is_second;
    logic             restart;
    logic [CNT_W-1:0] cnt;
    logic [IDX_W-1:0] idx_adv;
    byte_t            len_now;
    logic             done;
    logic             ok;

    mem_wr_t          wr;
    mem_rd_t          rd;
    result_t          result;

    always_comb
    begin
        rx.ready  = in_ready;
        accept    = rx.valid && in_ready;
        b         = rx.rx_byte;
        is_first  = (b == HDR_FIRST);
        is_second = (b == HDR_SECOND);
        restart   = is_second && hdr_reg;

        // Advance the count unsaturated; hold the index at the last entry.
        cnt       = {1'b0, idx_reg} + CNT_W'(1);
        idx_adv   = (cnt == DEPTH_CNT) ? LAST_IDX : cnt[IDX_W-1:0];

        if (!accept)
            idx_next = idx_reg;
        else if (restart)
            idx_next = IDX_ZERO;
        else
            idx_next = idx_adv;

        hdr_next  = accept ? is_first : hdr_reg;

        // Store the byte and extend the running sum.
        wr.en     = accept && !restart;
        wr.data   = b;
        wr.psum   = (idx_reg == IDX_ZERO) ? b : byte_t'(rd.prev_psum + b);

        // Completion and checksum test; only plain bytes can end a frame.
        len_now   = (idx_reg == IDX_ZERO) ? b : len_reg;
        done      = !is_first && !is_second && (CMP_W'(cnt) == CMP_W'(len_now));
        ok        = done && (idx_reg >= IDX_CHECK) && (rd.prev2_psum == rd.prev_byte);

        result.frame_done   = done;
        result.sum_ok       = ok;
        result.command_code = ok ? cmd_reg : NO_COMMAND;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            hdr_reg <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            hdr_reg <= hdr_next;
        end
    end

    // Shadow entries 0 and 1 so length and command need no extra read port.
    always_ff @(posedge clk)
    begin
        if (wr.en && (idx_reg == IDX_ZERO))
            len_reg <= b;
        if (wr.en && (idx_reg == IDX_CMD))
            cmd_reg <= b;
    end

    // Read the two entries below the index the next byte will use, registered in the store.
    scfr_frame_mem #(
        .DEPTH (BUFFER_DEPTH),
        .IDX_W (IDX_W)
    ) u_mem (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (wr),
        .wr_addr   (idx_reg),
        .rd_addr_a (idx_next - IDX_W'(1)),
        .rd_addr_b (idx_next - IDX_W'(2)),
        .rd        (rd)
    );

    scfr_out_buf u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept),
        .push_res   (result),
        .push_ready (in_ready),
        .res        (res)
    );

endmodule

// ===== rtl/core/scfr_checker.sv =====
// Port-level checks on the result channel of the frame receiver, and its bind.
// Depends on serial_command_frame_receiver_assert.svh and scfr_pkg.
`include "serial_command_frame_receiver_assert.svh"

module scfr_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            out_valid,
    input logic            out_ready,
    input logic            frame_done,
    input logic            sum_ok,
    input scfr_pkg::byte_t command_code
);
    import scfr_pkg::*;

    // Hold a stalled result word.
    `SCFR_ASSERT_NXT(a_res_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `SCFR_ASSERT_NXT(a_res_stable, clk, rst_n, out_valid && !out_ready, ($stable(frame_done) && $stable(sum_ok) && $stable(command_code)))
    // A passing check only comes with a finished frame.
    `SCFR_ASSERT_IMP(a_ok_needs_done, clk, rst_n, out_valid && sum_ok, frame_done)
    // Without a passing check the command is the no-command code.
    `SCFR_ASSERT_IMP(a_fail_code, clk, rst_n, out_valid && !sum_ok, command_code == NO_COMMAND)

endmodule

bind serial_command_frame_receiver scfr_checker u_scfr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (res.valid),
    .out_ready    (res.ready),
    .frame_done   (res.frame_done),
    .sum_ok       (res.sum_ok),
    .command_code (res.command_code)
);
